/* rtl/jmc_pkg.sv */
// ----------------------------------------------------------------------------
// jmc_pkg
// Shared types and constants of the joystick motion classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package jmc_pkg;

  // Field widths
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned CNT_W       = 10;                    // calibration count
  localparam int unsigned CSUM_W      = SAMPLE_BITS + CNT_W;   // calibration sum
  localparam int unsigned CMD_W       = 4;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 12;

  // Reset values
  localparam logic [CNT_W-1:0]       CAL_COUNT_RST = CNT_W'(120);
  localparam logic [SAMPLE_BITS-1:0] DEAD_ZONE_RST = SAMPLE_BITS'(380);
  localparam logic [SAMPLE_BITS-1:0] TURN_THR_RST  = SAMPLE_BITS'(650);
  localparam logic [SAMPLE_BITS-1:0] CENTER_RST    = SAMPLE_BITS'(2048);

  // Input function codes
  localparam logic FUNC_CALIB = 1'b0;
  localparam logic FUNC_DRIVE = 1'b1;

  // Result kinds
  localparam logic KIND_MOTION = 1'b0;
  localparam logic KIND_CALIB  = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CAL_COUNT = 2'd0,
    CFG_DEAD_ZONE = 2'd1,
    CFG_TURN_THR  = 2'd2
  } cfg_idx_e;

  // Motion commands
  typedef enum logic [CMD_W-1:0] {
    CMD_HALT = 4'd0,
    CMD_F    = 4'd1,
    CMD_B    = 4'd2,
    CMD_LF   = 4'd3,
    CMD_LB   = 4'd4,
    CMD_RF   = 4'd5,
    CMD_RB   = 4'd6,
    CMD_LH   = 4'd7,
    CMD_RH   = 4'd8
  } motion_cmd_e;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_CLS,
    ST_OUT
  } jmc_state_e;

  // Input beat
  typedef struct packed {
    logic                   func;
    logic [SAMPLE_BITS-1:0] x_sample;
    logic [SAMPLE_BITS-1:0] y_sample;
  } in_beat_t;

  // Output beat
  typedef struct packed {
    logic                   event_kind;
    logic [CMD_W-1:0]       motion_command;
    logic [SAMPLE_BITS-1:0] center_x_out;
    logic [SAMPLE_BITS-1:0] center_y_out;
  } out_beat_t;

  // Divider operands, both axes share one divisor
  typedef struct packed {
    logic [CSUM_W-1:0] num_x;
    logic [CSUM_W-1:0] num_y;
    logic [CNT_W-1:0]  divisor;
  } div_req_t;

endpackage

`default_nettype wire

/* rtl/jmc_div.sv */
// ----------------------------------------------------------------------------
// jmc_div
// Two-lane bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module jmc_div (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  input  wire jmc_pkg::div_req_t                   req_i,
  output logic                                     done_o,
  output logic [jmc_pkg::SAMPLE_BITS-1:0]          quot_x_o,
  output logic [jmc_pkg::SAMPLE_BITS-1:0]          quot_y_o
);

  localparam int unsigned DW = jmc_pkg::CSUM_W;
  localparam int unsigned VW = jmc_pkg::CNT_W;
  localparam int unsigned CW = $clog2(DW);

  // Dividend shift registers; quotient bits enter at the bottom
  logic [DW-1:0] num_x_q, num_y_q;
  logic [VW-1:0] rem_x_q, rem_y_q;
  logic [VW-1:0] div_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;

  logic [VW:0]   trial_x, trial_y;
  logic          ge_x, ge_y;
  logic [VW-1:0] rem_x_d, rem_y_d;

  // One restoring step per lane
  always_comb begin
    trial_x = {rem_x_q, num_x_q[DW-1]};
    trial_y = {rem_y_q, num_y_q[DW-1]};
    ge_x    = trial_x >= {1'b0, div_q};
    ge_y    = trial_y >= {1'b0, div_q};
    rem_x_d = ge_x ? VW'(trial_x - {1'b0, div_q}) : trial_x[VW-1:0];
    rem_y_d = ge_y ? VW'(trial_y - {1'b0, div_q}) : trial_y[VW-1:0];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CW'(1);
        if (cnt_q == CW'(DW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_x_q <= req_i.num_x;
      num_y_q <= req_i.num_y;
      div_q   <= req_i.divisor;
      rem_x_q <= '0;
      rem_y_q <= '0;
    end else if (busy_q) begin
      num_x_q <= {num_x_q[DW-2:0], ge_x};
      num_y_q <= {num_y_q[DW-2:0], ge_y};
      rem_x_q <= rem_x_d;
      rem_y_q <= rem_y_d;
    end
  end

  assign done_o   = done_q;
  assign quot_x_o = num_x_q[jmc_pkg::SAMPLE_BITS-1:0];
  assign quot_y_o = num_y_q[jmc_pkg::SAMPLE_BITS-1:0];

endmodule

`default_nettype wire

/* rtl/joystick_motion_classifier.sv */
// ----------------------------------------------------------------------------
// joystick_motion_classifier
// Turns joystick ADC sample pairs into calibration results and motion commands.
// ----------------------------------------------------------------------------
// Calibration pairs (func 0) are summed until calibration_count pairs are in;
// the floor averages then become the axis centers, the filters are preset to
// them and a calibration-finished beat goes out. Drive pairs (func 1) are
// averaged in groups of GROUP_SIZE, each average steps a 7/8 low-pass filter
// and the filtered offset from center is classified into one of nine motion
// commands. A pair that completes nothing leaves the block ready for the next
// pair. A pair that completes a calibration or a drive group keeps the input
// closed while the 22-step bit-serial divider, shared by calibration and group
// averaging, runs and the result is formed. The result sits in an output
// register, so the next pair is taken while it waits; a second result holds
// the block until the first beat has gone out. The configuration port is
// always ready.
`default_nettype none

module joystick_motion_classifier #(
  parameter int unsigned GROUP_SIZE = 5
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [jmc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [jmc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // sample pairs
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire jmc_pkg::in_beat_t                 in_data_i,
  // results
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output jmc_pkg::out_beat_t                     out_data_o
);

  localparam int unsigned SW     = jmc_pkg::SAMPLE_BITS;
  localparam int unsigned NW     = jmc_pkg::CNT_W;
  localparam int unsigned CSW    = jmc_pkg::CSUM_W;
  localparam int unsigned GW     = $clog2(GROUP_SIZE + 1);
  localparam int unsigned GSUM_W = SW + $clog2(GROUP_SIZE);
  localparam int unsigned FW     = SW + 3;

  // Configuration registers
  logic [NW-1:0] cal_count_q;
  logic [SW-1:0] dead_zone_q, turn_thr_q;

  // Block state
  logic [SW-1:0]     ctr_x_q, ctr_y_q, filt_x_q, filt_y_q;
  logic [CSW-1:0]    csum_x_q, csum_y_q;
  logic [NW-1:0]     cseen_q;
  logic [GSUM_W-1:0] gsum_x_q, gsum_y_q;
  logic [GW-1:0]     gseen_q;
  logic              calib_run_q;

  // Result register
  logic                 out_valid_q;
  jmc_pkg::out_beat_t   out_q;
  jmc_pkg::motion_cmd_e cmd_q;
  logic                 kind_q;

  jmc_pkg::jmc_state_e state_q, state_d;

  // Sequencer outputs
  logic in_fire, out_load;

  // Accumulation
  logic [CSW-1:0]    csum_x_n, csum_y_n;
  logic [NW-1:0]     cseen_n;
  logic [GSUM_W-1:0] gsum_x_n, gsum_y_n;
  logic [GW-1:0]     gseen_n;
  logic              cal_done, grp_done;

  // Divider
  logic              div_start, div_done;
  jmc_pkg::div_req_t div_req;
  logic [SW-1:0]     quot_x, quot_y;

  // Filter and classification
  logic [FW-1:0]        fsum_x, fsum_y;
  logic [SW:0]          dx, dy, ndx, ndy;
  logic [SW-1:0]        ax, ay;
  logic                 fwd;
  jmc_pkg::motion_cmd_e cmd_d;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == jmc_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  // Sums including the pair now offered
  always_comb begin
    csum_x_n = csum_x_q + CSW'(in_data_i.x_sample);
    csum_y_n = csum_y_q + CSW'(in_data_i.y_sample);
    cseen_n  = cseen_q + NW'(1);
    gsum_x_n = gsum_x_q + GSUM_W'(in_data_i.x_sample);
    gsum_y_n = gsum_y_q + GSUM_W'(in_data_i.y_sample);
    gseen_n  = gseen_q + GW'(1);
    cal_done = cseen_n >= cal_count_q;
    grp_done = gseen_n == GW'(GROUP_SIZE);
  end

  // Divider operands: calibration sums by pair count, or group sums by group size
  always_comb begin
    if (in_data_i.func == jmc_pkg::FUNC_CALIB) begin
      div_req.num_x   = csum_x_n;
      div_req.num_y   = csum_y_n;
      div_req.divisor = cseen_n;
      div_start       = in_fire && cal_done;
    end else begin
      div_req.num_x   = CSW'(gsum_x_n);
      div_req.num_y   = CSW'(gsum_y_n);
      div_req.divisor = NW'(GROUP_SIZE);
      div_start       = in_fire && grp_done;
    end
  end

  jmc_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .req_i    (div_req),
    .done_o   (div_done),
    .quot_x_o (quot_x),
    .quot_y_o (quot_y)
  );

  // Filter step: floor((7 * f + avg) / 8)
  always_comb begin
    fsum_x = {filt_x_q, 3'b000} - FW'(filt_x_q) + FW'(quot_x);
    fsum_y = {filt_y_q, 3'b000} - FW'(filt_y_q) + FW'(quot_y);
  end

  // Offset from center and command
  always_comb begin
    dx  = {1'b0, filt_x_q} - {1'b0, ctr_x_q};
    dy  = {1'b0, filt_y_q} - {1'b0, ctr_y_q};
    ndx = -dx;
    ndy = -dy;
    ax  = dx[SW] ? ndx[SW-1:0] : dx[SW-1:0];
    ay  = dy[SW] ? ndy[SW-1:0] : dy[SW-1:0];
    fwd = !dx[SW] && (dx != '0);
    if (ax < dead_zone_q && ay < dead_zone_q) begin
      cmd_d = jmc_pkg::CMD_HALT;
    end else if (ax >= dead_zone_q) begin
      if (ay < turn_thr_q) begin
        cmd_d = fwd ? jmc_pkg::CMD_F : jmc_pkg::CMD_B;
      end else if (dy[SW]) begin
        cmd_d = fwd ? jmc_pkg::CMD_LF : jmc_pkg::CMD_LB;
      end else begin
        cmd_d = fwd ? jmc_pkg::CMD_RF : jmc_pkg::CMD_RB;
      end
    end else begin
      cmd_d = dy[SW] ? jmc_pkg::CMD_LH : jmc_pkg::CMD_RH;
    end
  end

  // Next state
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    case (state_q)
      jmc_pkg::ST_IDLE: begin
        if (div_start) begin
          state_d = jmc_pkg::ST_DIV;
        end
      end
      jmc_pkg::ST_DIV: begin
        if (div_done) begin
          state_d = calib_run_q ? jmc_pkg::ST_OUT : jmc_pkg::ST_CLS;
        end
      end
      jmc_pkg::ST_CLS: begin
        state_d = jmc_pkg::ST_OUT;
      end
      jmc_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = jmc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = jmc_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= jmc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_count_q <= jmc_pkg::CAL_COUNT_RST;
      dead_zone_q <= jmc_pkg::DEAD_ZONE_RST;
      turn_thr_q  <= jmc_pkg::TURN_THR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        jmc_pkg::CFG_CAL_COUNT: cal_count_q <= cfg_data_i[NW-1:0];
        jmc_pkg::CFG_DEAD_ZONE: dead_zone_q <= cfg_data_i[SW-1:0];
        jmc_pkg::CFG_TURN_THR:  turn_thr_q  <= cfg_data_i[SW-1:0];
        default: ;
      endcase
    end
  end

  // Accumulators, centers and filters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_x_q     <= jmc_pkg::CENTER_RST;
      ctr_y_q     <= jmc_pkg::CENTER_RST;
      filt_x_q    <= jmc_pkg::CENTER_RST;
      filt_y_q    <= jmc_pkg::CENTER_RST;
      csum_x_q    <= '0;
      csum_y_q    <= '0;
      cseen_q     <= '0;
      gsum_x_q    <= '0;
      gsum_y_q    <= '0;
      gseen_q     <= '0;
      calib_run_q <= 1'b0;
      kind_q      <= jmc_pkg::KIND_MOTION;
      cmd_q       <= jmc_pkg::CMD_HALT;
    end else begin
      if (in_fire) begin
        if (in_data_i.func == jmc_pkg::FUNC_CALIB) begin
          // a calibration pair drops any partial drive group
          gsum_x_q    <= '0;
          gsum_y_q    <= '0;
          gseen_q     <= '0;
          calib_run_q <= 1'b1;
          if (cal_done) begin
            csum_x_q <= '0;
            csum_y_q <= '0;
            cseen_q  <= '0;
          end else begin
            csum_x_q <= csum_x_n;
            csum_y_q <= csum_y_n;
            cseen_q  <= cseen_n;
          end
        end else begin
          calib_run_q <= 1'b0;
          if (grp_done) begin
            gsum_x_q <= '0;
            gsum_y_q <= '0;
            gseen_q  <= '0;
          end else begin
            gsum_x_q <= gsum_x_n;
            gsum_y_q <= gsum_y_n;
            gseen_q  <= gseen_n;
          end
        end
      end
      // divider result lands
      if (state_q == jmc_pkg::ST_DIV && div_done) begin
        if (calib_run_q) begin
          ctr_x_q  <= quot_x;
          ctr_y_q  <= quot_y;
          filt_x_q <= quot_x;
          filt_y_q <= quot_y;
          kind_q   <= jmc_pkg::KIND_CALIB;
          cmd_q    <= jmc_pkg::CMD_HALT;
        end else begin
          filt_x_q <= fsum_x[FW-1:3];
          filt_y_q <= fsum_y[FW-1:3];
          kind_q   <= jmc_pkg::KIND_MOTION;
        end
      end
      if (state_q == jmc_pkg::ST_CLS) begin
        cmd_q <= cmd_d;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.event_kind     <= kind_q;
      out_q.motion_command <= cmd_q;
      out_q.center_x_out   <= ctr_x_q;
      out_q.center_y_out   <= ctr_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the joystick motion classifier.
// ----------------------------------------------------------------------------
// A directed opening covers the axis extremes, the calibration special cases
// (partial drive group dropped, count of zero, count lowered below progress)
// and a zero dead zone. Random phases follow, each under its own register
// settings: calibration runs around a chosen rest position, drive segments
// that hold a target for a few groups, and some noise and broken sequences.
// A bit-accurate predictor runs on every accepted input beat and its
// results are checked in order against the output beats.
// ----------------------------------------------------------------------------

module tb_top;
  import jmc_pkg::*;

  localparam int unsigned GROUP_SIZE     = 5;
  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned SETTLE_CYCLES  = 40;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned PHASE_PAIRS    = 200;
  localparam int unsigned HOLD_AT_PAIR   = 500;
  localparam int unsigned HOLD_CYCLES    = 400;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = CFG_CAL_COUNT;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  in_beat_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  out_beat_t             out_data_o;

  joystick_motion_classifier #(
    .GROUP_SIZE (GROUP_SIZE)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // --------------------------------------------------------------------------
  // Predictor state: registers and datapath copies
  // --------------------------------------------------------------------------
  logic [CNT_W-1:0]       cal_len  = CAL_COUNT_RST;
  logic [SAMPLE_BITS-1:0] dz_lim   = DEAD_ZONE_RST;
  logic [SAMPLE_BITS-1:0] turn_lim = TURN_THR_RST;

  logic [SAMPLE_BITS-1:0] ctr_x = CENTER_RST, ctr_y = CENTER_RST;
  logic [SAMPLE_BITS-1:0] flt_x = CENTER_RST, flt_y = CENTER_RST;
  logic [CSUM_W-1:0]      cal_sum_x = '0, cal_sum_y = '0;
  logic [CNT_W-1:0]       cal_n = '0;
  logic [14:0]            grp_sum_x = '0, grp_sum_y = '0;
  logic [2:0]             grp_n = '0;

  in_beat_t  stim_pairs[$];
  out_beat_t expected_results[$];

  int unsigned mismatches  = 0;
  int unsigned pairs_taken = 0;
  int unsigned hold_cnt    = 0;
  bit          hold_done   = 1'b0;

  // Generator's idea of the rest position
  int aim_x = 2048, aim_y = 2048;

  // Work out the result, if any, of one accepted pair
  function automatic void predict_pair(in_beat_t p);
    out_beat_t   r;
    motion_cmd_e cmd;
    int          dx, dy, ax, ay;
    r = '0;
    if (p.func == FUNC_CALIB) begin
      // a calibration pair drops any partial drive group
      grp_sum_x = '0;
      grp_sum_y = '0;
      grp_n     = '0;
      cal_sum_x = cal_sum_x + p.x_sample;
      cal_sum_y = cal_sum_y + p.y_sample;
      cal_n     = cal_n + 1'b1;
      if (cal_n < cal_len) return;
      ctr_x     = SAMPLE_BITS'(cal_sum_x / cal_n);
      ctr_y     = SAMPLE_BITS'(cal_sum_y / cal_n);
      flt_x     = ctr_x;
      flt_y     = ctr_y;
      cal_sum_x = '0;
      cal_sum_y = '0;
      cal_n     = '0;
      r.event_kind     = KIND_CALIB;
      r.motion_command = CMD_HALT;
    end else begin
      grp_sum_x = grp_sum_x + p.x_sample;
      grp_sum_y = grp_sum_y + p.y_sample;
      grp_n     = grp_n + 1'b1;
      if (grp_n < GROUP_SIZE) return;
      // 7/8 low-pass on the group averages
      flt_x = SAMPLE_BITS'((int'(flt_x) * 7 + int'(grp_sum_x) / GROUP_SIZE) / 8);
      flt_y = SAMPLE_BITS'((int'(flt_y) * 7 + int'(grp_sum_y) / GROUP_SIZE) / 8);
      grp_sum_x = '0;
      grp_sum_y = '0;
      grp_n     = '0;
      dx = int'(flt_x) - int'(ctr_x);
      dy = int'(flt_y) - int'(ctr_y);
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (ax < int'(dz_lim) && ay < int'(dz_lim)) begin
        cmd = CMD_HALT;
      end else if (ax >= int'(dz_lim)) begin
        if (ay < int'(turn_lim)) cmd = (dx > 0) ? CMD_F : CMD_B;
        else if (dy < 0)         cmd = (dx > 0) ? CMD_LF : CMD_LB;
        else                     cmd = (dx > 0) ? CMD_RF : CMD_RB;
      end else begin
        cmd = (dy < 0) ? CMD_LH : CMD_RH;
      end
      r.event_kind     = KIND_MOTION;
      r.motion_command = cmd;
    end
    r.center_x_out = ctr_x;
    r.center_y_out = ctr_y;
    expected_results.push_back(r);
  endfunction

  function automatic void check_field(string what, logic [11:0] want, logic [11:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  function automatic int unsigned draw_gap(bit calm);
    return calm ? 0 : $urandom_range(0, 12);
  endfunction

  // --------------------------------------------------------------------------
  // Input driver
  // --------------------------------------------------------------------------
  int unsigned in_gap  = 0;
  bit          in_calm = 1'b0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_pair(in_data_i);
        pairs_taken <= pairs_taken + 1;
        if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
        in_gap = draw_gap(in_calm);
      end
      // slot free: either nothing offered or the beat just went in
      if (!in_valid_i || in_ready_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (stim_pairs.size() != 0) begin
          in_valid_i <= 1'b1;
          in_data_i  <= stim_pairs.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long output hold-off, once, so the block backs up into its input
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (!hold_done && pairs_taken >= HOLD_AT_PAIR) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor and checker
  // --------------------------------------------------------------------------
  int unsigned out_gap  = 0;
  bit          out_calm = 1'b0;

  always @(posedge clk_i) begin : mon
    out_beat_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result beat, expected none, got kind %0d cmd %0d",
                   $time, out_data_o.event_kind, out_data_o.motion_command);
        end else begin
          want = expected_results.pop_front();
          check_field("event_kind", 12'(want.event_kind), 12'(out_data_o.event_kind));
          check_field("motion_command", 12'(want.motion_command),
                      12'(out_data_o.motion_command));
          check_field("center_x_out", want.center_x_out, out_data_o.center_x_out);
          check_field("center_y_out", want.center_y_out, out_data_o.center_y_out);
        end
        if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
        out_gap = draw_gap(out_calm);
      end
      if (out_gap != 0) begin
        out_gap--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= (hold_cnt == 0);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without any beat on any channel
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void push_pair(logic func, logic [11:0] xs, logic [11:0] ys);
    in_beat_t p;
    p.func     = func;
    p.x_sample = xs;
    p.y_sample = ys;
    stim_pairs.push_back(p);
  endfunction

  function automatic logic [11:0] jitter(int c, int unsigned s);
    int v;
    v = c + int'($urandom_range(0, 2 * s)) - int'(s);
    if (v < 0) v = 0;
    if (v > 4095) v = 4095;
    return 12'(v);
  endfunction

  // Register write; the predictor copy changes on the same beat
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_CAL_COUNT: cal_len  = data[CNT_W-1:0];
      CFG_DEAD_ZONE: dz_lim   = data;
      CFG_TURN_THR:  turn_lim = data;
      default: ;
    endcase
  endtask

  // Wait until every pair is in and every result is out, then let it settle
  task automatic drain();
    while (stim_pairs.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Mostly well-formed calibration runs and drive segments, some noise
  task automatic gen_traffic(int unsigned n_pairs, int unsigned run_len);
    int unsigned left, k, reps, spread;
    int          tx, ty;
    left = n_pairs;
    while (left > 0) begin
      k = $urandom_range(0, 9);
      if (k == 0) begin
        push_pair(1'($urandom_range(0, 1)), 12'($urandom_range(0, 4095)),
                  12'($urandom_range(0, 4095)));
        reps = 1;
      end else if (k <= 2) begin
        // calibration run around a fresh rest position
        aim_x = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) : int'(jitter(2048, 300));
        aim_y = $urandom_range(0, 1) ? int'($urandom_range(0, 4095)) : int'(jitter(2048, 300));
        reps  = (run_len > 40) ? $urandom_range(1, 40) : run_len;
        if ($urandom_range(0, 7) == 0) reps = $urandom_range(1, reps);
        for (int i = 0; i < reps; i++)
          push_pair(FUNC_CALIB, jitter(aim_x, 30), jitter(aim_y, 30));
      end else begin
        // drive segment holding one target for a few groups
        spread = $urandom_range(0, 1) ? $urandom_range(0, 400) : $urandom_range(0, 1600);
        if ($urandom_range(0, 3) == 0) begin
          tx = int'($urandom_range(0, 4095));
          ty = int'($urandom_range(0, 4095));
        end else begin
          tx = int'(jitter(aim_x, spread));
          ty = int'(jitter(aim_y, spread));
        end
        reps = $urandom_range(1, 6) * GROUP_SIZE;
        if ($urandom_range(0, 7) == 0) reps = $urandom_range(1, reps);
        for (int i = 0; i < reps; i++)
          push_pair(FUNC_DRIVE, jitter(tx, 25), jitter(ty, 25));
      end
      left = (reps >= left) ? 0 : left - reps;
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [CFG_DATA_W-1:0] cc, dz, tt;
    int unsigned           run_len;

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: one full group at the extremes, then a partial group
    // cut by calibration pairs, then drive pairs while calibration is open
    for (int i = 0; i < GROUP_SIZE; i++) push_pair(FUNC_DRIVE, 12'hFFF, 12'h000);
    for (int i = 0; i < 3; i++) push_pair(FUNC_DRIVE, 12'h000, 12'hFFF);
    push_pair(FUNC_CALIB, 12'hFFF, 12'hFFF);
    push_pair(FUNC_CALIB, 12'h000, 12'h000);
    push_pair(FUNC_DRIVE, 12'h000, 12'h000);
    push_pair(FUNC_DRIVE, 12'hFFF, 12'hFFF);
    drain();

    // Count lowered below progress: next calibration pair finishes
    write_reg(CFG_CAL_COUNT, 12'd1);
    push_pair(FUNC_CALIB, 12'd2048, 12'd1000);
    drain();

    // Count of zero, zero dead zone: centered filter gives back
    write_reg(CFG_CAL_COUNT, 12'h400);
    write_reg(CFG_DEAD_ZONE, 12'd0);
    write_reg(CFG_TURN_THR, 12'hFFF);
    push_pair(FUNC_CALIB, 12'h000, 12'hFFF);
    for (int i = 0; i < GROUP_SIZE; i++) push_pair(FUNC_DRIVE, 12'h000, 12'hFFF);
    drain();

    write_reg(CFG_TURN_THR, 12'd0);
    for (int i = 0; i < GROUP_SIZE; i++) push_pair(FUNC_DRIVE, 12'hFFF, 12'h000);
    drain();

    // Random phases, extremes of the registers first
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin cc = 12'd1;   dz = 12'd0;   tt = 12'd0;   end
        1: begin cc = 12'h3FF; dz = 12'hFFF; tt = 12'hFFF; end
        2: begin cc = 12'd4;   dz = 12'd380; tt = 12'd650; end
        3: begin
          cc = 12'hC00;
          dz = 12'($urandom_range(0, 700));
          tt = 12'($urandom_range(0, 1200));
        end
        default: begin
          cc = 12'($urandom_range(1, 12)) | (12'($urandom_range(0, 3)) << CNT_W);
          dz = 12'($urandom_range(0, 700));
          tt = 12'($urandom_range(0, 1200));
        end
      endcase
      write_reg(CFG_CAL_COUNT, cc);
      write_reg(CFG_DEAD_ZONE, dz);
      write_reg(CFG_TURN_THR, tt);
      run_len = (cc[CNT_W-1:0] == 0) ? 1 : cc[CNT_W-1:0];
      gen_traffic(PHASE_PAIRS, run_len);
      drain();
    end

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
